FILE: design/vcs_pkg.sv
package vcs_pkg;

    localparam int AXIS_COUNT = 3;
    localparam int VEL_W      = 16;
    localparam int LIM_W      = 15;
    localparam int FRAC_W     = 16;
    localparam int CMD_W      = 2;
    localparam int KEY_W      = 2;
    localparam int BTN_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MUL_W      = 18;

    localparam int AXIS_X   = 0;
    localparam int AXIS_Y   = 1;
    localparam int AXIS_YAW = 2;

    localparam logic [CMD_W-1:0] CMD_PLAN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_JOY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    localparam logic signed [KEY_W-1:0] KEY_LEFT  = -2'sd1;
    localparam logic signed [KEY_W-1:0] KEY_RIGHT = 2'sd1;

    localparam int BTN_MOVE_OFF = 0;
    localparam int BTN_MOVE_ON  = 1;
    localparam int BTN_AUTO_OFF = 2;
    localparam int BTN_AUTO_ON  = 3;
    localparam int BTN_DOCK_OFF = 6;
    localparam int BTN_DOCK_ON  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_YAW_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_RATIO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP_THRESHOLD = 3'd4;

    localparam logic [LIM_W-1:0]  MAX_SPEED_RST      = 15'd2048;
    localparam logic [LIM_W-1:0]  MAX_YAW_RATE_RST   = 15'd4096;
    localparam logic [FRAC_W-1:0] YAW_RATIO_RST      = 16'd32768;
    localparam logic [FRAC_W-1:0] SMOOTHING_GAIN_RST = 16'd19661;
    localparam logic [LIM_W-1:0]  SNAP_THRESHOLD_RST = 15'd4;

    typedef logic signed [VEL_W-1:0] vel_t;

    typedef struct packed {
        logic              load_plan;
        logic              load_joy;
        logic              load_tick;
        logic              use_auto;
        logic              stop_mode;
        logic              docked;
        logic              key_neg;
        logic              key_zero;
        logic              commit;
        logic [FRAC_W-1:0] gain;
        logic [LIM_W-1:0]  thr;
    } lane_ctl_t;

    typedef struct packed {
        logic velocity_valid;
        logic dock_pulse;
        logic undock_pulse;
        logic auto_active;
        logic move_enabled;
    } res_flags_t;

endpackage

FILE: design/vcs_if.sv
interface vcs_in_if;
    import vcs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [VEL_W-1:0]  plan_vx;
    logic signed [VEL_W-1:0]  plan_vy;
    logic signed [VEL_W-1:0]  plan_wz;
    logic signed [VEL_W-1:0]  stick_fwd;
    logic signed [VEL_W-1:0]  stick_side;
    logic signed [KEY_W-1:0]  yaw_key;
    logic [BTN_W-1:0]         buttons;

    modport source (
        output valid, command, plan_vx, plan_vy, plan_wz, stick_fwd, stick_side,
               yaw_key, buttons,
        input  ready
    );
    modport sink (
        input  valid, command, plan_vx, plan_vy, plan_wz, stick_fwd, stick_side,
               yaw_key, buttons,
        output ready
    );
endinterface

interface vcs_out_if;
    import vcs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] out_vx;
    logic signed [VEL_W-1:0] out_vy;
    logic signed [VEL_W-1:0] out_wz;
    logic                    velocity_valid;
    logic                    dock_pulse;
    logic                    undock_pulse;
    logic                    auto_active;
    logic                    move_enabled;

    modport source (
        output valid, out_vx, out_vy, out_wz, velocity_valid, dock_pulse,
               undock_pulse, auto_active, move_enabled,
        input  ready
    );
    modport sink (
        input  valid, out_vx, out_vy, out_wz, velocity_valid, dock_pulse,
               undock_pulse, auto_active, move_enabled,
        output ready
    );
endinterface

interface vcs_cfg_if;
    import vcs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/vcs_lane.sv
module vcs_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vcs_pkg::lane_ctl_t               ctl,
    input  logic                             yaw_lane,
    input  vcs_pkg::vel_t                    plan_val,
    input  logic signed [vcs_pkg::MUL_W-1:0] joy_a,
    input  logic signed [vcs_pkg::MUL_W-1:0] joy_b,
    input  logic [vcs_pkg::LIM_W-1:0]        lim,
    output vcs_pkg::vel_t                    v
);
    import vcs_pkg::*;

    localparam int PROD_W = 2 * MUL_W;
    localparam logic [FRAC_W:0] ONE_Q16 = 17'h10000;
    localparam logic signed [PROD_W-1:0] HALF16 = 36'sd32768;
    localparam logic signed [PROD_W-1:0] HALF14 = 36'sd8192;

    function automatic vel_t sat16(input logic signed [21:0] x);
        if (x > 22'sd32767)
            return 16'sh7fff;
        else if (x < -22'sd32768)
            return 16'sh8000;
        else
            return x[VEL_W-1:0];
    endfunction

    vel_t plan_reg, man_reg, cur_reg;
    vel_t tgt;
    logic signed [VEL_W:0] diff;
    logic [VEL_W:0] adiff;
    logic snap;
    logic [FRAC_W:0] gain2, factor;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    logic signed [PROD_W-1:0] prod_reg;
    logic snap_reg, tick_reg, joy_reg, docked_reg, stop_reg, neg_reg, zero_reg;
    vel_t tgt_reg;

    logic signed [PROD_W-1:0] r16, r14;
    logic signed [20:0] sum;
    logic signed [21:0] jr;
    vel_t new_cur, jsat, jres, clamped;
    logic [VEL_W-1:0] acur;
    logic signed [VEL_W:0] v17, lim17;

    // issue side
    always_comb
    begin
        tgt   = ctl.stop_mode ? '0 : (ctl.use_auto ? plan_reg : man_reg);
        diff  = {tgt[VEL_W-1], tgt} - {cur_reg[VEL_W-1], cur_reg};
        adiff = diff[VEL_W] ? (VEL_W+1)'(-diff) : (VEL_W+1)'(diff);
        snap  = adiff < {2'b00, ctl.thr};
        gain2 = {ctl.gain, 1'b0};
        if (ctl.stop_mode)
            factor = (gain2 > ONE_Q16) ? ONE_Q16 : gain2;
        else
            factor = {1'b0, ctl.gain};
        if (ctl.load_tick)
        begin
            mul_a = {diff[VEL_W], diff};
            mul_b = {1'b0, factor};
        end
        else
        begin
            mul_a = joy_a;
            mul_b = joy_b;
        end
        prod = mul_a * mul_b;
    end

    // commit side
    always_comb
    begin
        r16 = prod_reg + HALF16;
        r14 = prod_reg + HALF14;
        sum = {{5{cur_reg[VEL_W-1]}}, cur_reg} + {r16[PROD_W-1], r16[PROD_W-1:16]};
        new_cur = snap_reg ? tgt_reg : sat16({sum[20], sum});
        jr = yaw_lane ? {{2{r16[PROD_W-1]}}, r16[PROD_W-1:16]} : r14[PROD_W-1:14];
        jsat = sat16(jr);
        if (yaw_lane && zero_reg)
            jres = '0;
        else if (yaw_lane && neg_reg)
            jres = -jsat;
        else
            jres = jsat;

        acur  = new_cur[VEL_W-1] ? VEL_W'(-new_cur) : VEL_W'(new_cur);
        v17   = {new_cur[VEL_W-1], new_cur};
        lim17 = {2'b00, lim};
        if (v17 > lim17)
            clamped = {1'b0, lim};
        else if (v17 < -lim17)
            clamped = -vel_t'({1'b0, lim});
        else
            clamped = new_cur;

        if (docked_reg)
            v = '0;
        else if (stop_reg)
            v = (acur < {1'b0, ctl.thr}) ? '0 : new_cur;
        else
            v = clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_reg <= '0;
            man_reg  <= '0;
            cur_reg  <= '0;
        end
        else
        begin
            if (ctl.load_plan)
                plan_reg <= plan_val;
            if (ctl.commit && joy_reg)
                man_reg <= jres;
            if (ctl.commit && tick_reg && !docked_reg)
                cur_reg <= new_cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_tick || ctl.load_joy)
        begin
            prod_reg   <= prod;
            snap_reg   <= snap;
            tgt_reg    <= tgt;
            tick_reg   <= ctl.load_tick;
            joy_reg    <= ctl.load_joy;
            docked_reg <= ctl.docked;
            stop_reg   <= ctl.stop_mode;
            neg_reg    <= ctl.key_neg;
            zero_reg   <= ctl.key_zero;
        end
    end

endmodule

FILE: design/vcs_merge.sv
module vcs_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  vcs_pkg::vel_t          vel [vcs_pkg::AXIS_COUNT],
    input  vcs_pkg::res_flags_t    flags,
    output logic                   slot_free,
    vcs_out_if.source              res
);
    import vcs_pkg::*;

    logic       valid_reg;
    vel_t       vel_reg [AXIS_COUNT];
    res_flags_t flags_reg;

    assign slot_free = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (res.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vel_reg   <= vel;
            flags_reg <= flags;
        end
    end

    assign res.valid          = valid_reg;
    assign res.out_vx         = vel_reg[AXIS_X];
    assign res.out_vy         = vel_reg[AXIS_Y];
    assign res.out_wz         = vel_reg[AXIS_YAW];
    assign res.velocity_valid = flags_reg.velocity_valid;
    assign res.dock_pulse     = flags_reg.dock_pulse;
    assign res.undock_pulse   = flags_reg.undock_pulse;
    assign res.auto_active    = flags_reg.auto_active;
    assign res.move_enabled   = flags_reg.move_enabled;

endmodule

FILE: design/velocity_command_smoother.sv
// Three-axis velocity smoother. Planner items and unused commands are taken every cycle;
// a joystick item is taken every cycle as long as the stage behind the multipliers can
// drain. For a tick, one lane per axis first multiplies the remaining difference by
// the gain into a register; then, once the output register is free, it rounds, snaps,
// clamps and writes the axis state, so a tick directly behind a tick or joystick item
// waits until that stage has drained. The result leaves from an output register; a new
// item is accepted while it waits there. Configuration writes are taken every cycle.
module velocity_command_smoother (
    input  logic      clk,
    input  logic      rst_n,
    vcs_in_if.sink    cmd_ch,
    vcs_out_if.source res_ch,
    vcs_cfg_if.sink   cfg_ch
);
    import vcs_pkg::*;

    logic [LIM_W-1:0]  max_speed_reg, max_yaw_rate_reg, snap_threshold_reg;
    logic [FRAC_W-1:0] yaw_ratio_reg, smoothing_gain_reg;
    logic auto_reg, move_reg, dock_reg, dock_prev_reg;

    logic       p_valid_reg, p_tick_reg;
    res_flags_t p_flags_reg;

    logic in_acc, p_adv, slot_free;
    logic is_joy, is_tick;
    logic auto_next, move_next, dock_next;
    lane_ctl_t ctl;

    vel_t plan_vals [AXIS_COUNT];
    logic signed [MUL_W-1:0] joy_a [AXIS_COUNT];
    logic signed [MUL_W-1:0] joy_b [AXIS_COUNT];
    logic [LIM_W-1:0] lims [AXIS_COUNT];
    vel_t lane_v [AXIS_COUNT];

    assign cfg_ch.ready = 1'b1;

    assign p_adv  = p_valid_reg && (!p_tick_reg || slot_free);
    assign in_acc = cmd_ch.valid && cmd_ch.ready;
    assign is_joy  = cmd_ch.command == CMD_JOY;
    assign is_tick = cmd_ch.command == CMD_TICK;

    always_comb
    begin
        case (cmd_ch.command)
            CMD_TICK: cmd_ch.ready = !p_valid_reg;
            CMD_JOY:  cmd_ch.ready = !p_valid_reg || p_adv;
            default:  cmd_ch.ready = 1'b1;
        endcase
    end

    always_comb
    begin
        auto_next = auto_reg;
        move_next = move_reg;
        dock_next = dock_reg;
        if (cmd_ch.buttons[BTN_AUTO_OFF])
            auto_next = 1'b0;
        else if (cmd_ch.buttons[BTN_AUTO_ON])
            auto_next = 1'b1;
        if (cmd_ch.buttons[BTN_MOVE_OFF])
            move_next = 1'b0;
        else if (cmd_ch.buttons[BTN_MOVE_ON])
            move_next = 1'b1;
        if (cmd_ch.buttons[BTN_DOCK_OFF])
            dock_next = 1'b0;
        else if (cmd_ch.buttons[BTN_DOCK_ON])
            dock_next = 1'b1;
    end

    always_comb
    begin
        ctl.load_plan = in_acc && (cmd_ch.command == CMD_PLAN);
        ctl.load_joy  = in_acc && is_joy;
        ctl.load_tick = in_acc && is_tick;
        ctl.use_auto  = auto_reg;
        ctl.stop_mode = !move_reg;
        ctl.docked    = dock_reg;
        ctl.key_neg   = cmd_ch.yaw_key == KEY_RIGHT;
        ctl.key_zero  = !(cmd_ch.yaw_key == KEY_RIGHT || cmd_ch.yaw_key == KEY_LEFT);
        ctl.commit    = p_adv;
        ctl.gain      = smoothing_gain_reg;
        ctl.thr       = snap_threshold_reg;
    end

    assign plan_vals[AXIS_X]   = cmd_ch.plan_vx;
    assign plan_vals[AXIS_Y]   = cmd_ch.plan_vy;
    assign plan_vals[AXIS_YAW] = cmd_ch.plan_wz;
    assign joy_a[AXIS_X]   = MUL_W'(cmd_ch.stick_fwd);
    assign joy_a[AXIS_Y]   = MUL_W'(cmd_ch.stick_side);
    assign joy_a[AXIS_YAW] = {2'b00, yaw_ratio_reg};
    assign joy_b[AXIS_X]   = {3'b000, max_speed_reg};
    assign joy_b[AXIS_Y]   = {3'b000, max_speed_reg};
    assign joy_b[AXIS_YAW] = {3'b000, max_yaw_rate_reg};
    assign lims[AXIS_X]   = max_speed_reg;
    assign lims[AXIS_Y]   = max_speed_reg;
    assign lims[AXIS_YAW] = max_yaw_rate_reg;

    for (genvar g = 0; g < AXIS_COUNT; g++)
    begin : g_lane
        vcs_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .yaw_lane (g == AXIS_YAW),
            .plan_val (plan_vals[g]),
            .joy_a    (joy_a[g]),
            .joy_b    (joy_b[g]),
            .lim      (lims[g]),
            .v        (lane_v[g])
        );
    end

    vcs_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (p_adv && p_tick_reg),
        .vel       (lane_v),
        .flags     (p_flags_reg),
        .slot_free (slot_free),
        .res       (res_ch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg      <= MAX_SPEED_RST;
            max_yaw_rate_reg   <= MAX_YAW_RATE_RST;
            yaw_ratio_reg      <= YAW_RATIO_RST;
            smoothing_gain_reg <= SMOOTHING_GAIN_RST;
            snap_threshold_reg <= SNAP_THRESHOLD_RST;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.index)
                REG_MAX_SPEED:      max_speed_reg      <= cfg_ch.data[LIM_W-1:0];
                REG_MAX_YAW_RATE:   max_yaw_rate_reg   <= cfg_ch.data[LIM_W-1:0];
                REG_YAW_RATIO:      yaw_ratio_reg      <= cfg_ch.data[FRAC_W-1:0];
                REG_SMOOTHING_GAIN: smoothing_gain_reg <= cfg_ch.data[FRAC_W-1:0];
                REG_SNAP_THRESHOLD: snap_threshold_reg <= cfg_ch.data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg      <= 1'b0;
            move_reg      <= 1'b1;
            dock_reg      <= 1'b0;
            dock_prev_reg <= 1'b0;
            p_valid_reg   <= 1'b0;
            p_tick_reg    <= 1'b0;
            p_flags_reg   <= '0;
        end
        else
        begin
            if (in_acc && is_joy)
            begin
                auto_reg <= auto_next;
                move_reg <= move_next;
                dock_reg <= dock_next;
            end
            if (in_acc && is_tick)
            begin
                dock_prev_reg              <= dock_reg;
                p_flags_reg.velocity_valid <= !dock_reg;
                p_flags_reg.dock_pulse     <= dock_reg && !dock_prev_reg;
                p_flags_reg.undock_pulse   <= !dock_reg && dock_prev_reg;
                p_flags_reg.auto_active    <= auto_reg;
                p_flags_reg.move_enabled   <= move_reg;
            end
            if (in_acc && (is_joy || is_tick))
            begin
                p_valid_reg <= 1'b1;
                p_tick_reg  <= is_tick;
            end
            else if (p_adv)
                p_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: design/vcs_checker.sv
module vcs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [vcs_pkg::CMD_W-1:0]      in_command,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic signed [vcs_pkg::VEL_W-1:0] out_vx,
    input logic signed [vcs_pkg::VEL_W-1:0] out_vy,
    input logic signed [vcs_pkg::VEL_W-1:0] out_wz,
    input logic                           velocity_valid,
    input logic                           dock_pulse,
    input logic                           undock_pulse
);
    import vcs_pkg::*;

    logic tick_acc;
    assign tick_acc = in_valid && in_ready && (in_command == CMD_TICK);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_vx) && $stable(out_vy)
            && $stable(out_wz) && $stable(velocity_valid) && $stable(dock_pulse))
        else $error("result changed while stalled");

    a_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(dock_pulse && undock_pulse))
        else $error("dock and undock pulse together");

    a_docked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !velocity_valid |-> out_vx == 0 && out_vy == 0 && out_wz == 0)
        else $error("docked tick with nonzero velocity");

    a_dock_novel: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && dock_pulse |-> !velocity_valid)
        else $error("velocity issued on dock edge");

    a_tick_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc |=> !tick_acc)
        else $error("tick accepted while previous tick in flight");

endmodule

bind velocity_command_smoother vcs_checker u_vcs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (cmd_ch.valid),
    .in_ready       (cmd_ch.ready),
    .in_command     (cmd_ch.command),
    .res_valid      (res_ch.valid),
    .res_ready      (res_ch.ready),
    .out_vx         (res_ch.out_vx),
    .out_vy         (res_ch.out_vy),
    .out_wz         (res_ch.out_wz),
    .velocity_valid (res_ch.velocity_valid),
    .dock_pulse     (res_ch.dock_pulse),
    .undock_pulse   (res_ch.undock_pulse)
);

FILE: test/velocity_command_smoother_tb.sv
`timescale 1ns / 1ps

module velocity_command_smoother_tb;
    import vcs_pkg::*;

    localparam logic [CMD_W-1:0]         CMD_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0]     REG_UNUSED  = 3'd5;
    localparam logic signed [KEY_W-1:0]  KEY_NONE    = 2'sd0;
    localparam logic signed [KEY_W-1:0]  KEY_INVALID = -2'sd2;

    localparam logic [BTN_W-1:0] B_MOVE_OFF = 8'(1 << BTN_MOVE_OFF);
    localparam logic [BTN_W-1:0] B_MOVE_ON  = 8'(1 << BTN_MOVE_ON);
    localparam logic [BTN_W-1:0] B_AUTO_OFF = 8'(1 << BTN_AUTO_OFF);
    localparam logic [BTN_W-1:0] B_AUTO_ON  = 8'(1 << BTN_AUTO_ON);
    localparam logic [BTN_W-1:0] B_DOCK_OFF = 8'(1 << BTN_DOCK_OFF);
    localparam logic [BTN_W-1:0] B_DOCK_ON  = 8'(1 << BTN_DOCK_ON);

    localparam longint UNITY_Q16     = 65536;
    localparam int     GAP_MAX       = 11;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     DRAIN_LIMIT   = 6000;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        vel_t                    plan_vx;
        vel_t                    plan_vy;
        vel_t                    plan_wz;
        vel_t                    stick_fwd;
        vel_t                    stick_side;
        logic signed [KEY_W-1:0] yaw_key;
        logic [BTN_W-1:0]        buttons;
    } cmd_item_t;

    typedef struct packed {
        vel_t       vx;
        vel_t       vy;
        vel_t       wz;
        res_flags_t flags;
    } tick_output_t;

    logic clk;
    logic rst_n;

    vcs_in_if  cmd_ch ();
    vcs_out_if res_ch ();
    vcs_cfg_if cfg_ch ();

    velocity_command_smoother dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .res_ch (res_ch),
        .cfg_ch (cfg_ch)
    );

    // smoother copy
    logic [LIM_W-1:0]  lim_speed;
    logic [LIM_W-1:0]  lim_yaw;
    logic [FRAC_W-1:0] yaw_frac;
    logic [FRAC_W-1:0] gain_frac;
    logic [LIM_W-1:0]  snap_thr;
    logic              mode_auto;
    logic              mode_move;
    logic              mode_dock;
    logic              dock_seen;
    vel_t              plan_goal [AXIS_COUNT];
    vel_t              stick_goal [AXIS_COUNT];
    vel_t              vel_now [AXIS_COUNT];

    tick_output_t tick_outputs_due [$];

    int   fail_count;
    bit   tx_gaps_on;
    bit   rx_stalls_on;
    bit   rx_hold_req;
    int   rx_hold_len;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("velocity_command_smoother: mismatch");
        $finish;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        fail_count++;
        if (fail_count <= 40)
            $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic longint round_q(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint sat_vel(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic vel_t approach(vel_t cur, vel_t goal, longint factor);
        longint diff;
        longint mag;
        diff = longint'(goal) - longint'(cur);
        mag = (diff < 0) ? -diff : diff;
        if (mag < longint'(snap_thr))
            return goal;
        return vel_t'(sat_vel(longint'(cur) + round_q(diff * factor, 16)));
    endfunction

    function automatic vel_t clamp_vel(vel_t v, logic [LIM_W-1:0] lim);
        longint l;
        l = longint'(lim);
        if (longint'(v) > l)
            return vel_t'(l);
        if (longint'(v) < -l)
            return vel_t'(-l);
        return v;
    endfunction

    function automatic void reset_smoother();
        lim_speed = MAX_SPEED_RST;
        lim_yaw   = MAX_YAW_RATE_RST;
        yaw_frac  = YAW_RATIO_RST;
        gain_frac = SMOOTHING_GAIN_RST;
        snap_thr  = SNAP_THRESHOLD_RST;
        mode_auto = 1'b0;
        mode_move = 1'b1;
        mode_dock = 1'b0;
        dock_seen = 1'b0;
        for (int i = 0; i < AXIS_COUNT; i++)
        begin
            plan_goal[i]  = '0;
            stick_goal[i] = '0;
            vel_now[i]    = '0;
        end
    endfunction

    function automatic void advance_smoother(cmd_item_t it);
        tick_output_t r;
        vel_t         v [AXIS_COUNT];
        longint       f;
        longint       yaw;
        longint       mag;
        case (it.command)
            CMD_PLAN:
            begin
                plan_goal[AXIS_X]   = it.plan_vx;
                plan_goal[AXIS_Y]   = it.plan_vy;
                plan_goal[AXIS_YAW] = it.plan_wz;
            end
            CMD_JOY:
            begin
                if (it.buttons[BTN_AUTO_OFF])
                    mode_auto = 1'b0;
                else if (it.buttons[BTN_AUTO_ON])
                    mode_auto = 1'b1;
                if (it.buttons[BTN_MOVE_OFF])
                    mode_move = 1'b0;
                else if (it.buttons[BTN_MOVE_ON])
                    mode_move = 1'b1;
                if (it.buttons[BTN_DOCK_OFF])
                    mode_dock = 1'b0;
                else if (it.buttons[BTN_DOCK_ON])
                    mode_dock = 1'b1;
                stick_goal[AXIS_X] = vel_t'(sat_vel(round_q(
                    longint'(it.stick_fwd) * longint'(lim_speed), 14)));
                stick_goal[AXIS_Y] = vel_t'(sat_vel(round_q(
                    longint'(it.stick_side) * longint'(lim_speed), 14)));
                yaw = round_q(longint'(yaw_frac) * longint'(lim_yaw), 16);
                if (it.yaw_key == KEY_LEFT)
                    stick_goal[AXIS_YAW] = vel_t'(yaw);
                else if (it.yaw_key == KEY_RIGHT)
                    stick_goal[AXIS_YAW] = vel_t'(-yaw);
                else
                    stick_goal[AXIS_YAW] = '0;
            end
            CMD_TICK:
            begin
                r = '0;
                for (int i = 0; i < AXIS_COUNT; i++)
                    v[i] = '0;
                if (mode_dock)
                    r.flags.dock_pulse = !dock_seen;
                else
                begin
                    r.flags.undock_pulse   = dock_seen;
                    r.flags.velocity_valid = 1'b1;
                    if (mode_move)
                    begin
                        for (int i = 0; i < AXIS_COUNT; i++)
                        begin
                            vel_now[i] = approach(vel_now[i],
                                mode_auto ? plan_goal[i] : stick_goal[i],
                                longint'(gain_frac));
                            v[i] = clamp_vel(vel_now[i], (i == AXIS_YAW) ? lim_yaw : lim_speed);
                        end
                    end
                    else
                    begin
                        f = 2 * longint'(gain_frac);
                        if (f > UNITY_Q16)
                            f = UNITY_Q16;
                        for (int i = 0; i < AXIS_COUNT; i++)
                        begin
                            vel_now[i] = approach(vel_now[i], vel_t'(0), f);
                            mag = longint'(vel_now[i]);
                            if (mag < 0)
                                mag = -mag;
                            v[i] = (mag < longint'(snap_thr)) ? vel_t'(0) : vel_now[i];
                        end
                    end
                end
                dock_seen = mode_dock;
                r.vx = v[AXIS_X];
                r.vy = v[AXIS_Y];
                r.wz = v[AXIS_YAW];
                r.flags.auto_active  = mode_auto;
                r.flags.move_enabled = mode_move;
                tick_outputs_due.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin : result_check
        tick_output_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (tick_outputs_due.size() == 0)
                report_mismatch("item with none expected, out_vx", res_ch.out_vx, 0);
            else
            begin
                want = tick_outputs_due.pop_front();
                if (res_ch.out_vx !== want.vx)
                    report_mismatch("out_vx", res_ch.out_vx, want.vx);
                if (res_ch.out_vy !== want.vy)
                    report_mismatch("out_vy", res_ch.out_vy, want.vy);
                if (res_ch.out_wz !== want.wz)
                    report_mismatch("out_wz", res_ch.out_wz, want.wz);
                if (res_ch.velocity_valid !== want.flags.velocity_valid)
                    report_mismatch("velocity_valid", res_ch.velocity_valid,
                        want.flags.velocity_valid);
                if (res_ch.dock_pulse !== want.flags.dock_pulse)
                    report_mismatch("dock_pulse", res_ch.dock_pulse, want.flags.dock_pulse);
                if (res_ch.undock_pulse !== want.flags.undock_pulse)
                    report_mismatch("undock_pulse", res_ch.undock_pulse,
                        want.flags.undock_pulse);
                if (res_ch.auto_active !== want.flags.auto_active)
                    report_mismatch("auto_active", res_ch.auto_active, want.flags.auto_active);
                if (res_ch.move_enabled !== want.flags.move_enabled)
                    report_mismatch("move_enabled", res_ch.move_enabled,
                        want.flags.move_enabled);
            end
        end
    end

    // result receiver
    initial
    begin : receiver
        int n;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (rx_hold_len) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            n = rx_stalls_on ? $urandom_range(0, GAP_MAX) : 0;
            if (n > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_ch.valid === 1'b1 && res_ch.ready === 1'b1) && !rx_hold_req);
        end
    end

    task automatic send_item(cmd_item_t it);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.command    <= it.command;
        cmd_ch.plan_vx    <= it.plan_vx;
        cmd_ch.plan_vy    <= it.plan_vy;
        cmd_ch.plan_wz    <= it.plan_wz;
        cmd_ch.stick_fwd  <= it.stick_fwd;
        cmd_ch.stick_side <= it.stick_side;
        cmd_ch.yaw_key    <= it.yaw_key;
        cmd_ch.buttons    <= it.buttons;
        cmd_ch.valid      <= 1'b1;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        advance_smoother(it);
    endtask

    // sender stops until every expected item is back or DRAIN_LIMIT is reached
    task automatic settle();
        int waited;
        waited = 0;
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (tick_outputs_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (tick_outputs_due.size() != 0)
        begin
            report_mismatch("items never arrived, count", tick_outputs_due.size(), 0);
            tick_outputs_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            REG_MAX_SPEED:      lim_speed = val[LIM_W-1:0];
            REG_MAX_YAW_RATE:   lim_yaw   = val[LIM_W-1:0];
            REG_YAW_RATIO:      yaw_frac  = val;
            REG_SMOOTHING_GAIN: gain_frac = val;
            REG_SNAP_THRESHOLD: snap_thr  = val[LIM_W-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(logic [CFG_DATA_W-1:0] speed, logic [CFG_DATA_W-1:0] yaw,
                                  logic [CFG_DATA_W-1:0] ratio, logic [CFG_DATA_W-1:0] gain,
                                  logic [CFG_DATA_W-1:0] thr);
        write_reg(REG_MAX_SPEED, speed);
        write_reg(REG_MAX_YAW_RATE, yaw);
        write_reg(REG_YAW_RATIO, ratio);
        write_reg(REG_SMOOTHING_GAIN, gain);
        write_reg(REG_SNAP_THRESHOLD, thr);
    endtask

    task automatic random_settings();
        logic [CFG_DATA_W-1:0] lim_val [2];
        logic [CFG_DATA_W-1:0] gain_val;
        logic [CFG_DATA_W-1:0] thr_val;
        for (int k = 0; k < 2; k++)
            case ($urandom_range(0, 4))
                0:       lim_val[k] = 16'($urandom);
                1:       lim_val[k] = 16'h7FFF;
                2:       lim_val[k] = 16'($urandom_range(0, 255));
                default: lim_val[k] = 16'($urandom_range(256, 8192));
            endcase
        case ($urandom_range(0, 4))
            0:       gain_val = 16'($urandom);
            1:       gain_val = 16'hFFFF;
            2:       gain_val = 16'($urandom_range(32768, 65535));
            default: gain_val = 16'($urandom_range(2000, 30000));
        endcase
        case ($urandom_range(0, 4))
            0:       thr_val = 16'($urandom);
            1:       thr_val = '0;
            default: thr_val = 16'($urandom_range(1, 64));
        endcase
        apply_settings(lim_val[0], lim_val[1], 16'($urandom), gain_val, thr_val);
    endtask

    function automatic cmd_item_t noise_item(logic [CMD_W-1:0] cmd);
        cmd_item_t it;
        it.command    = cmd;
        it.plan_vx    = vel_t'($urandom);
        it.plan_vy    = vel_t'($urandom);
        it.plan_wz    = vel_t'($urandom);
        it.stick_fwd  = vel_t'($urandom);
        it.stick_side = vel_t'($urandom);
        it.yaw_key    = 2'($urandom_range(0, 3));
        it.buttons    = 8'($urandom);
        return it;
    endfunction

    function automatic vel_t rand_stick();
        case ($urandom_range(0, 9))
            0:       return 16384;
            1:       return -16384;
            2:       return vel_t'($urandom);
            3:       return vel_t'($urandom_range(0, 16) - 8);
            default: return vel_t'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic vel_t rand_speed();
        case ($urandom_range(0, 9))
            0:       return 32767;
            1:       return -32768;
            2, 3, 4: return vel_t'($urandom);
            5, 6:    return vel_t'($urandom_range(0, 128) - 64);
            default: return vel_t'($urandom_range(0, 16384) - 8192);
        endcase
    endfunction

    function automatic cmd_item_t rand_item();
        cmd_item_t it;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            it = noise_item(CMD_TICK);
        else if (pick < 70)
        begin
            it = noise_item(CMD_JOY);
            it.stick_fwd  = rand_stick();
            it.stick_side = rand_stick();
            case ($urandom_range(0, 19))
                9:       it.buttons = B_MOVE_OFF;
                10:      it.buttons = B_MOVE_ON;
                11:      it.buttons = B_AUTO_OFF;
                12:      it.buttons = B_AUTO_ON;
                13:      it.buttons = B_DOCK_ON;
                14, 15:  it.buttons = B_DOCK_OFF;
                16, 17:  ;
                18:      it.buttons = B_AUTO_ON | B_MOVE_ON;
                19:      it.buttons = B_AUTO_OFF | B_MOVE_ON;
                default: it.buttons = '0;
            endcase
        end
        else if (pick < 97)
        begin
            it = noise_item(CMD_PLAN);
            it.plan_vx = rand_speed();
            it.plan_vy = rand_speed();
            it.plan_wz = rand_speed();
        end
        else
            it = noise_item(CMD_UNUSED);
        return it;
    endfunction

    task automatic send_ticks(int n);
        repeat (n) send_item(noise_item(CMD_TICK));
    endtask

    task automatic send_plan(vel_t vx, vel_t vy, vel_t wz);
        cmd_item_t it;
        it = noise_item(CMD_PLAN);
        it.plan_vx = vx;
        it.plan_vy = vy;
        it.plan_wz = wz;
        send_item(it);
    endtask

    task automatic send_stick(vel_t fwd, vel_t side, logic signed [KEY_W-1:0] key,
                              logic [BTN_W-1:0] btn);
        cmd_item_t it;
        it = noise_item(CMD_JOY);
        it.stick_fwd  = fwd;
        it.stick_side = side;
        it.yaw_key    = key;
        it.buttons    = btn;
        send_item(it);
    endtask

    task automatic run_random(int count);
        cmd_item_t it;
        int        n;
        n = 0;
        while (n < count)
        begin
            it = rand_item();
            send_item(it);
            if (it.command != CMD_UNUSED)
                n++;
        end
    endtask

    task automatic test_directed();
        send_ticks(1);
        send_stick(16384, -16384, KEY_LEFT, '0);
        send_ticks(3);
        // off beats on for move
        send_stick(-16384, 16384, KEY_RIGHT, B_MOVE_OFF | B_MOVE_ON);
        send_ticks(2);
        send_plan(32767, -32768, 16'sh1234);
        send_stick(-32768, 32767, KEY_INVALID, B_AUTO_ON | B_MOVE_ON);
        send_ticks(2);
        send_stick(0, 0, KEY_NONE, B_DOCK_ON);
        send_ticks(2);
        // half-way rounding on both signs
        send_stick(4, -4, KEY_NONE, B_DOCK_OFF | B_DOCK_ON | B_AUTO_OFF | B_AUTO_ON);
        send_ticks(1);
        send_item(noise_item(CMD_UNUSED));
        send_plan(-32768, 32767, -1);
        send_stick(1, -1, KEY_NONE, 8'hFF);
        send_ticks(1);
        send_stick(16384, 16384, KEY_LEFT, B_AUTO_ON | B_MOVE_ON);
        send_ticks(1);
        settle();
    endtask

    task automatic test_config_extremes();
        apply_settings(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        run_random(60);
        settle();
        apply_settings('0, '0, '0, '0, '0);
        run_random(60);
        settle();
        // top bit dropped on 15-bit regs, stop-mode factor saturates
        apply_settings(16'hFFFF, 16'h8800, 16'hFFFF, 16'hFFFF, 16'h8000);
        run_random(60);
        settle();
        write_reg(REG_UNUSED, 16'($urandom));
        apply_settings(16'(MAX_SPEED_RST), 16'(MAX_YAW_RATE_RST), YAW_RATIO_RST,
                       SMOOTHING_GAIN_RST, 16'(SNAP_THRESHOLD_RST));
        run_random(40);
        settle();
    endtask

    task automatic test_backpressure();
        tx_gaps_on  = 1'b0;
        rx_hold_len = 300;
        rx_hold_req = 1'b1;
        for (int k = 0; k < 48; k++)
            if (k % 4 == 0)
                send_stick(rand_stick(), rand_stick(), 2'($urandom_range(0, 3)),
                           B_MOVE_ON | B_DOCK_OFF);
            else
                send_ticks(1);
        settle();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random();
        for (int c = 0; c < 12; c++)
        begin
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            if (c == 0)
            begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end
            else
                random_settings();
            run_random(65);
            settle();
            run_random(65);
            settle();
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= CMD_PLAN;
        cmd_ch.plan_vx    <= '0;
        cmd_ch.plan_vy    <= '0;
        cmd_ch.plan_wz    <= '0;
        cmd_ch.stick_fwd  <= '0;
        cmd_ch.stick_side <= '0;
        cmd_ch.yaw_key    <= KEY_NONE;
        cmd_ch.buttons    <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_MAX_SPEED;
        cfg_ch.data       <= '0;
        fail_count   = 0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        rx_hold_req  = 1'b0;
        rx_hold_len  = 0;
        reset_smoother();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();

        if (fail_count == 0)
            $display("velocity_command_smoother: match");
        else
            $display("velocity_command_smoother: mismatch");
        $finish;
    end

endmodule
